### rtl/addressable_led_serializer_macros.svh
// Assertion macros for the serializer's RTL.
`ifndef ADDRESSABLE_LED_SERIALIZER_MACROS_SVH
`define ADDRESSABLE_LED_SERIALIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define ALS_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("als: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define ALS_FOLLOWS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("als: next-cycle check failed");
`else
`define ALS_HOLDS(label, clk, rst, ante, cons)
`define ALS_FOLLOWS(label, clk, rst, ante, cons)
`endif
`endif

### rtl/als_pkg.sv
package als_pkg;

  localparam int OP_W       = 2;
  localparam int COORD_W    = 4;
  localparam int COLOR_BITS = 8;
  localparam int WORD_W     = 3 * COLOR_BITS;
  localparam int TICK_W     = 16;
  localparam int LATCH_W    = 20;
  localparam int GRID_W     = 5;
  localparam int PIX_W      = 2 * GRID_W;
  localparam int BIT_W      = 5;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int DEF_MAX_COLUMNS = 16;
  localparam int DEF_MAX_ROWS    = 16;

  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF      = 3'd7;

  localparam logic [TICK_W-1:0]  DEF_ONE_HIGH  = 16'd50;
  localparam logic [TICK_W-1:0]  DEF_ONE_LOW   = 16'd14;
  localparam logic [TICK_W-1:0]  DEF_ZERO_HIGH = 16'd16;
  localparam logic [TICK_W-1:0]  DEF_ZERO_LOW  = 16'd50;
  localparam logic [LATCH_W-1:0] DEF_LATCH     = 20'd50000;
  localparam logic [GRID_W-1:0]  DEF_COLUMNS   = 5'd8;
  localparam logic [GRID_W-1:0]  DEF_ROWS      = 5'd1;
  localparam logic               DEF_HALF      = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]       opcode;
    logic [COORD_W-1:0]    column;
    logic [COORD_W-1:0]    row;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } item_t;

  typedef struct packed {
    logic                data_out;
    logic                busy_res;
    logic                frame_done;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic [PIX_W-1:0]  index;
    logic [GRID_W-1:0] cols;
  } loc_req_t;

  typedef struct packed {
    logic              done;
    logic [GRID_W-1:0] row;
    logic [GRID_W-1:0] col;
  } loc_rsp_t;

endpackage

### rtl/als_ram.sv
module als_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/als_locate.sv
module als_locate (
  input  logic              clk,
  input  logic              rst,
  input  als_pkg::loc_req_t req,
  output als_pkg::loc_rsp_t rsp
);
  import als_pkg::*;

  localparam int CNT_W = $clog2(PIX_W);

  logic              running;
  logic              done;
  logic [CNT_W-1:0]  step;
  logic [PIX_W-1:0]  dividend;
  logic [PIX_W-1:0]  quotient;
  logic [GRID_W-1:0] divisor;
  logic [GRID_W-1:0] remainder;
  logic [GRID_W:0]   trial;
  logic              fits;
  logic [GRID_W-1:0] rem_next;

  // Restoring division: one quotient bit per cycle, most significant first.
  always_comb begin
    trial    = {remainder, dividend[PIX_W-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? GRID_W'(trial - {1'b0, divisor}) : trial[GRID_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (req.valid) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == CNT_W'(PIX_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      dividend  <= req.index;
      divisor   <= req.cols;
      remainder <= '0;
      quotient  <= '0;
    end else if (running) begin
      dividend  <= {dividend[PIX_W-2:0], 1'b0};
      remainder <= rem_next;
      quotient  <= {quotient[PIX_W-2:0], fits};
    end
  end

  // The pixel index is always below the frame size, so the row fits the grid width.
  assign rsp.done = done;
  assign rsp.row  = quotient[GRID_W-1:0];
  assign rsp.col  = remainder;

endmodule

### rtl/addressable_led_serializer.sv
// Channel  Dir  Signals                          Transfer
// item     in   start, item (item_t)             taken at a clock edge with start & !busy
// result   out  valid, result (result_t)         one cycle per item, marked by valid
// config   in   cfg_write, cfg_index, cfg_data   written at a clock edge with cfg_write
//
// Set-pixel, start and most tick items commit when taken; the result shows the cycle after.
// A tick that ends the latch or a pixel's last bit fetches the next pixel word: the index
// divider works out the row and column, then the memory is read and the update is made;
// busy stays high through these steps and the result follows.
// After reset the pixel memory is cleared, one word a cycle, all MAX_COLUMNS * MAX_ROWS
// words (256 by default) with busy high. The receiver cannot hold results off.
`include "addressable_led_serializer_macros.svh"

module addressable_led_serializer #(
  parameter int MAX_COLUMNS = als_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = als_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  als_pkg::item_t                     item,
  output logic                               valid,
  output als_pkg::result_t                   result,
  input  logic                               cfg_write,
  input  logic [als_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [als_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import als_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    SQ_CLEAR  = 4'b0001,
    SQ_IDLE   = 4'b0010,
    SQ_LOCATE = 4'b0100,
    SQ_LOAD   = 4'b1000
  } seq_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_LATCH = 4'b0010,
    PH_HIGH  = 4'b0100,
    PH_LOW   = 4'b1000
  } phase_t;

  // Configuration registers.
  logic [TICK_W-1:0]  one_high;
  logic [TICK_W-1:0]  one_low;
  logic [TICK_W-1:0]  zero_high;
  logic [TICK_W-1:0]  zero_low;
  logic [LATCH_W-1:0] latch_len;
  logic [GRID_W-1:0]  grid_columns;
  logic [GRID_W-1:0]  grid_rows;
  logic               half;

  // Sequencer and serializer state.
  seq_t               seq;
  phase_t             phase;
  phase_t             phase_next;
  logic [LATCH_W-1:0] tick_count;
  logic [LATCH_W-1:0] tick_next;
  logic [BIT_W-1:0]   bit_index;
  logic [BIT_W-1:0]   bit_next;
  logic [PIX_W-1:0]   pixel_index;
  logic [PIX_W-1:0]   pix_next;
  logic [WORD_W-1:0]  shift_word;
  logic [WORD_W-1:0]  shift_next;
  logic [ADDR_W-1:0]  clr_addr;
  item_t              item_hold;
  result_t            res_next;

  // Exec signals.
  item_t              cur;
  logic [GRID_W-1:0]  used_cols;
  logic [GRID_W-1:0]  used_rows;
  logic [PIX_W-1:0]   total;
  logic [LATCH_W-1:0] tick_inc;
  logic [PIX_W-1:0]   pix_inc;
  logic               one_bit;
  logic               latch_hit;
  logic               high_hit;
  logic               low_hit;
  logic               last_bit;
  logic               more_pix;
  logic               need_load;
  logic               set_ok;
  logic               commit;
  logic               frame_busy;
  logic [COLOR_BITS-1:0] red_s;
  logic [COLOR_BITS-1:0] green_s;
  logic [COLOR_BITS-1:0] blue_s;

  // Memory and divider connections.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;
  logic [ADDR_W-1:0]  set_addr;
  loc_req_t           loc_req;
  loc_rsp_t           loc_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high     <= DEF_ONE_HIGH;
      one_low      <= DEF_ONE_LOW;
      zero_high    <= DEF_ZERO_HIGH;
      zero_low     <= DEF_ZERO_LOW;
      latch_len    <= DEF_LATCH;
      grid_columns <= DEF_COLUMNS;
      grid_rows    <= DEF_ROWS;
      half         <= DEF_HALF;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ONE_HIGH:  one_high     <= cfg_data[TICK_W-1:0];
        CFG_ONE_LOW:   one_low      <= cfg_data[TICK_W-1:0];
        CFG_ZERO_HIGH: zero_high    <= cfg_data[TICK_W-1:0];
        CFG_ZERO_LOW:  zero_low     <= cfg_data[TICK_W-1:0];
        CFG_LATCH:     latch_len    <= cfg_data[LATCH_W-1:0];
        CFG_COLUMNS:   grid_columns <= cfg_data[GRID_W-1:0];
        CFG_ROWS:      grid_rows    <= cfg_data[GRID_W-1:0];
        CFG_HALF:      half         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign used_cols = (int'(grid_columns) < MAX_COLUMNS) ? grid_columns : GRID_W'(MAX_COLUMNS);
  assign used_rows = (int'(grid_rows) < MAX_ROWS) ? grid_rows : GRID_W'(MAX_ROWS);
  assign total     = PIX_W'(used_cols) * PIX_W'(used_rows);

  // While a word is being fetched the held item is replayed; the state has not moved.
  assign cur = (seq == SQ_IDLE) ? item : item_hold;

  always_comb begin
    frame_busy = phase != PH_IDLE;
    tick_inc   = tick_count + 1'b1;
    pix_inc    = pixel_index + 1'b1;
    one_bit    = shift_word[WORD_W-1];
    latch_hit  = tick_inc >= latch_len;
    high_hit   = tick_inc >= LATCH_W'(one_bit ? one_high : zero_high);
    low_hit    = tick_inc >= LATCH_W'(one_bit ? one_low : zero_low);
    last_bit   = bit_index == BIT_W'(WORD_W - 1);
    more_pix   = pix_inc < total;
    need_load  = (cur.opcode == OP_TICK) &&
                 (((phase == PH_LATCH) && latch_hit && (total != '0)) ||
                  ((phase == PH_LOW) && low_hit && last_bit && more_pix));

    red_s   = half ? {1'b0, cur.red[COLOR_BITS-1:1]}   : cur.red;
    green_s = half ? {1'b0, cur.green[COLOR_BITS-1:1]} : cur.green;
    blue_s  = half ? {1'b0, cur.blue[COLOR_BITS-1:1]}  : cur.blue;

    phase_next = phase;
    tick_next  = tick_count;
    bit_next   = bit_index;
    pix_next   = pixel_index;
    shift_next = shift_word;
    set_ok     = 1'b0;
    res_next   = '0;
    res_next.status = STATUS_OK;

    case (cur.opcode)
      OP_SET: begin
        res_next.data_out = phase == PH_HIGH;
        if (frame_busy) begin
          res_next.status = STATUS_BUSY;
        end else if ({1'b0, cur.column} >= used_cols || {1'b0, cur.row} >= used_rows) begin
          res_next.status = STATUS_RANGE;
        end else begin
          set_ok = 1'b1;
        end
      end
      OP_START: begin
        if (frame_busy) begin
          res_next.status   = STATUS_BUSY;
          res_next.data_out = phase == PH_HIGH;
        end else begin
          phase_next = PH_LATCH;
          tick_next  = '0;
          pix_next   = '0;
          bit_next   = '0;
        end
      end
      OP_TICK: begin
        case (phase)
          PH_LATCH: begin
            tick_next = tick_inc;
            if (latch_hit) begin
              tick_next = '0;
              if (total == '0) begin
                phase_next          = PH_IDLE;
                res_next.frame_done = 1'b1;
              end else begin
                pix_next   = '0;
                bit_next   = '0;
                shift_next = ram_rdata;
                phase_next = PH_HIGH;
              end
            end
          end
          PH_HIGH: begin
            res_next.data_out = 1'b1;
            tick_next         = tick_inc;
            if (high_hit) begin
              tick_next  = '0;
              phase_next = PH_LOW;
            end
          end
          PH_LOW: begin
            tick_next = tick_inc;
            if (low_hit) begin
              tick_next  = '0;
              shift_next = {shift_word[WORD_W-2:0], 1'b0};
              bit_next   = bit_index + 1'b1;
              phase_next = PH_HIGH;
              if (last_bit) begin
                bit_next = '0;
                if (!more_pix) begin
                  pix_next            = '0;
                  phase_next          = PH_IDLE;
                  res_next.frame_done = 1'b1;
                end else begin
                  pix_next   = pix_inc;
                  shift_next = ram_rdata;
                end
              end
            end
          end
          default: ;
        endcase
      end
      default: begin
        res_next.data_out = phase == PH_HIGH;
      end
    endcase

    res_next.busy_res = phase_next != PH_IDLE;
  end

  assign commit = ((seq == SQ_IDLE) && start && !need_load) || (seq == SQ_LOAD);
  assign busy   = seq != SQ_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= SQ_CLEAR;
      clr_addr    <= '0;
      valid       <= 1'b0;
      phase       <= PH_IDLE;
      tick_count  <= '0;
      bit_index   <= '0;
      pixel_index <= '0;
      shift_word  <= '0;
    end else begin
      valid <= commit;
      if (commit) begin
        phase       <= phase_next;
        tick_count  <= tick_next;
        bit_index   <= bit_next;
        pixel_index <= pix_next;
        shift_word  <= shift_next;
      end
      case (seq)
        SQ_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            seq <= SQ_IDLE;
          end
        end
        SQ_IDLE: begin
          if (start && need_load) begin
            seq <= SQ_LOCATE;
          end
        end
        SQ_LOCATE: begin
          if (loc_rsp.done) begin
            seq <= SQ_LOAD;
          end
        end
        SQ_LOAD: begin
          seq <= SQ_IDLE;
        end
        default: begin
          seq <= SQ_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (seq == SQ_IDLE && start) begin
      item_hold <= item;
    end
    if (commit) begin
      result <= res_next;
    end
  end

  // The next word's index: the first pixel after the latch, otherwise the following one.
  assign loc_req.valid = (seq == SQ_IDLE) && start && need_load;
  assign loc_req.index = (phase == PH_LATCH) ? '0 : pix_inc;
  assign loc_req.cols  = used_cols;

  als_locate u_locate (
    .clk (clk),
    .rst (rst),
    .req (loc_req),
    .rsp (loc_rsp)
  );

  // Pixels are only written while no frame runs, so a fetch never meets a pending write.
  assign set_addr  = ADDR_W'(int'(cur.row) * MAX_COLUMNS + int'(cur.column));
  assign ram_we    = (seq == SQ_CLEAR) || (commit && set_ok);
  assign ram_waddr = (seq == SQ_CLEAR) ? clr_addr : set_addr;
  assign ram_wdata = (seq == SQ_CLEAR) ? '0 : {green_s, red_s, blue_s};
  assign ram_raddr = ADDR_W'(int'(loc_rsp.row) * MAX_COLUMNS + int'(loc_rsp.col));

  als_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_pixels (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `ALS_HOLDS(a_loc_done_while_waiting, clk, rst, loc_rsp.done, seq == SQ_LOCATE)
  `ALS_HOLDS(a_no_pixel_write_in_frame, clk, rst, ram_we && seq != SQ_CLEAR, phase == PH_IDLE)
  `ALS_FOLLOWS(a_load_gives_result, clk, rst, seq == SQ_LOAD, valid)
  `ALS_HOLDS(a_frame_end_idle, clk, rst, valid && result.frame_done, phase == PH_IDLE)

endmodule
